// ===== hdl/bfpa_pkg.sv =====
// shared types and constants for the best-fit pool allocator
package bfpa_pkg;

  localparam int unsigned POOL_BYTES = 8192;
  localparam int unsigned HDR_BYTES  = 24;
  localparam int unsigned MAX_TILES  = 512;

  // offsets inside the pool, tile table index, tile count
  localparam int unsigned OFS_W  = $clog2(POOL_BYTES);
  localparam int unsigned ADDR_W = $clog2(MAX_TILES);
  localparam int unsigned CNT_W  = $clog2(MAX_TILES + 1);
  // width for compares against 16-bit request fields
  localparam int unsigned CMP_W  = 17;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_NOFIT    = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_NOTALLOC = 3'd4;

  typedef struct packed {
    logic        opcode;
    logic [15:0] req_size;
    logic [15:0] address;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [12:0] payload_offset;
  } out_beat_t;

  // one entry of the tile table
  typedef struct packed {
    logic [OFS_W-1:0] start;
    logic [OFS_W-1:0] size;
    logic             used;
  } tile_t;

  localparam int unsigned TILE_W = $bits(tile_t);

endpackage

// ===== hdl/bfpa_ram.sv =====
// generic simple dual-port ram with registered read
module bfpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/bfpa_ctrl.sv =====
// sequencer that scans, splits, merges and shifts the tile table
module bfpa_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  bfpa_pkg::in_beat_t                  cmd,
  output logic                                res_valid,
  input  logic                                res_ready,
  output bfpa_pkg::out_beat_t                 res,
  output logic                                rd_en,
  output logic [bfpa_pkg::ADDR_W-1:0]         rd_addr,
  input  logic [bfpa_pkg::TILE_W-1:0]         rd_data,
  output logic                                wr_en,
  output logic [bfpa_pkg::ADDR_W-1:0]         wr_addr,
  output logic [bfpa_pkg::TILE_W-1:0]         wr_data
);

  typedef enum logic [8:0] {
    S_INIT      = 9'b000000001,
    S_IDLE      = 9'b000000010,
    S_SCAN      = 9'b000000100,
    S_ALC_SHIFT = 9'b000001000,
    S_ALC_NEW   = 9'b000010000,
    S_ALC_MARK  = 9'b000100000,
    S_FRE_NEXT  = 9'b001000000,
    S_FRE_MERGE = 9'b010000000,
    S_FRE_SHIFT = 9'b100000000
  } state_t;

  localparam int unsigned OW = bfpa_pkg::OFS_W;
  localparam int unsigned AW = bfpa_pkg::ADDR_W;
  localparam int unsigned CW = bfpa_pkg::CNT_W;
  localparam int unsigned XW = bfpa_pkg::CMP_W;

  state_t               state, state_next;
  logic                 resp, resp_next;
  logic [CW-1:0]        cnt, cnt_next;
  logic                 op, op_next;
  logic [15:0]          req, req_next;
  logic [15:0]          addr, addr_next;
  logic [CW-1:0]        ptr, ptr_next;
  logic                 pend, pend_next;
  logic [AW-1:0]        rd_at, rd_at_next;
  logic                 found, found_next;
  logic [AW-1:0]        idx, idx_next;
  bfpa_pkg::tile_t      cur, cur_next;
  bfpa_pkg::tile_t      prv, prv_next;
  bfpa_pkg::tile_t      upd, upd_next;
  logic [1:0]           gap, gap_next;
  logic [2:0]           status, status_next;
  logic [12:0]          offset, offset_next;

  bfpa_pkg::tile_t      rt;
  bfpa_pkg::tile_t      wt;
  logic                 issue;
  logic                 nf, pf;
  logic [XW-1:0]        hdr_x;

  assign rt       = bfpa_pkg::tile_t'(rd_data);
  assign wr_data  = bfpa_pkg::TILE_W'(wt);
  assign hdr_x    = XW'(bfpa_pkg::HDR_BYTES);

  assign cmd_ready = (state == S_IDLE) && !resp;
  assign res_valid = resp;
  assign res.status         = status;
  assign res.payload_offset = offset;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      resp  <= 1'b0;
      cnt   <= CW'(1);
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      resp  <= resp_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op     <= op_next;
    req    <= req_next;
    addr   <= addr_next;
    ptr    <= ptr_next;
    rd_at  <= rd_at_next;
    found  <= found_next;
    idx    <= idx_next;
    cur    <= cur_next;
    prv    <= prv_next;
    upd    <= upd_next;
    gap    <= gap_next;
    status <= status_next;
    offset <= offset_next;
  end

  // sequencer
  always_comb begin
    state_next  = state;
    resp_next   = resp;
    cnt_next    = cnt;
    op_next     = op;
    req_next    = req;
    addr_next   = addr;
    ptr_next    = ptr;
    pend_next   = 1'b0;
    rd_at_next  = rd_at;
    found_next  = found;
    idx_next    = idx;
    cur_next    = cur;
    prv_next    = prv;
    upd_next    = upd;
    gap_next    = gap;
    status_next = status;
    offset_next = offset;
    rd_en       = 1'b0;
    rd_addr     = ptr[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = idx;
    wt          = upd;
    issue       = 1'b0;
    nf          = 1'b0;
    pf          = 1'b0;

    if (resp && res_ready) begin
      resp_next = 1'b0;
    end

    unique case (state)
      // single pool-wide free tile
      S_INIT: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        wt.start   = '0;
        wt.size    = OW'(bfpa_pkg::POOL_BYTES - bfpa_pkg::HDR_BYTES);
        wt.used    = 1'b0;
        state_next = S_IDLE;
      end

      S_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          op_next     = cmd.opcode;
          req_next    = cmd.req_size;
          addr_next   = cmd.address;
          ptr_next    = '0;
          found_next  = 1'b0;
          offset_next = '0;
          status_next = bfpa_pkg::ST_DONE;
          if (cmd.opcode == bfpa_pkg::OP_ALLOC && cmd.req_size == '0) begin
            status_next = bfpa_pkg::ST_ZERO;
            resp_next   = 1'b1;
          end else if (cmd.opcode == bfpa_pkg::OP_FREE &&
                       {1'b0, cmd.address} >= XW'(bfpa_pkg::POOL_BYTES)) begin
            status_next = bfpa_pkg::ST_RANGE;
            resp_next   = 1'b1;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      // walk the table in address order
      S_SCAN: begin
        issue = (ptr < cnt);
        if (issue) begin
          rd_en      = 1'b1;
          ptr_next   = ptr + CW'(1);
          pend_next  = 1'b1;
          rd_at_next = ptr[AW-1:0];
        end
        if (pend && op == bfpa_pkg::OP_ALLOC) begin
          if (!rt.used && XW'(rt.size) >= XW'(req) &&
              (!found || rt.size < cur.size)) begin
            found_next = 1'b1;
            idx_next   = rd_at;
            cur_next   = rt;
          end
        end
        if (pend && op == bfpa_pkg::OP_FREE) begin
          if (rt.used && XW'(rt.start) + hdr_x == XW'(addr)) begin
            idx_next   = rd_at;
            cur_next   = rt;
            pend_next  = 1'b0;
            state_next = S_FRE_NEXT;
          end else begin
            prv_next = rt;
          end
        end
        if (!issue && !pend) begin
          if (op == bfpa_pkg::OP_FREE) begin
            status_next = bfpa_pkg::ST_NOTALLOC;
            resp_next   = 1'b1;
            state_next  = S_IDLE;
          end else if (!found) begin
            status_next = bfpa_pkg::ST_NOFIT;
            resp_next   = 1'b1;
            state_next  = S_IDLE;
          end else begin
            offset_next = 13'(XW'(cur.start) + hdr_x);
            upd_next    = cur;
            upd_next.used = 1'b1;
            if (XW'(cur.size) > XW'(req) + hdr_x && cnt < CW'(bfpa_pkg::MAX_TILES)) begin
              upd_next.size = OW'(req);
              ptr_next      = cnt - CW'(1);
              state_next    = S_ALC_SHIFT;
            end else begin
              state_next = S_ALC_MARK;
            end
          end
        end
      end

      // move entries above the split tile up by one
      S_ALC_SHIFT: begin
        issue = (ptr > CW'(idx));
        if (issue) begin
          rd_en      = 1'b1;
          ptr_next   = ptr - CW'(1);
          pend_next  = 1'b1;
          rd_at_next = ptr[AW-1:0];
        end
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = rd_at + AW'(1);
          wt      = rt;
        end
        if (!issue && !pend) begin
          state_next = S_ALC_NEW;
        end
      end

      // free remainder after the split
      S_ALC_NEW: begin
        wr_en      = 1'b1;
        wr_addr    = idx + AW'(1);
        wt.start   = OW'(XW'(cur.start) + hdr_x + XW'(req));
        wt.size    = OW'(XW'(cur.size) - XW'(req) - hdr_x);
        wt.used    = 1'b0;
        cnt_next   = cnt + CW'(1);
        state_next = S_ALC_MARK;
      end

      S_ALC_MARK: begin
        wr_en      = 1'b1;
        resp_next  = 1'b1;
        state_next = S_IDLE;
      end

      // fetch the next neighbour
      S_FRE_NEXT: begin
        rd_en      = 1'b1;
        rd_addr    = idx + AW'(1);
        state_next = S_FRE_MERGE;
      end

      // coalesce with free neighbours
      S_FRE_MERGE: begin
        nf = (CW'(idx) + CW'(1) < cnt) && !rt.used;
        pf = (idx != '0) && !prv.used;
        wr_en = 1'b1;
        wt.used = 1'b0;
        if (pf) begin
          wr_addr  = idx - AW'(1);
          wt.start = prv.start;
          wt.size  = OW'(XW'(prv.size) + hdr_x + XW'(cur.size) +
                         (nf ? hdr_x + XW'(rt.size) : '0));
          ptr_next = CW'(idx) + (nf ? CW'(2) : CW'(1));
          gap_next = nf ? 2'd2 : 2'd1;
        end else begin
          wr_addr  = idx;
          wt.start = cur.start;
          wt.size  = nf ? OW'(XW'(cur.size) + hdr_x + XW'(rt.size)) : cur.size;
          ptr_next = CW'(idx) + CW'(2);
          gap_next = nf ? 2'd1 : 2'd0;
        end
        if (pf || nf) begin
          state_next = S_FRE_SHIFT;
        end else begin
          resp_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      // close the gap left by merged tiles
      S_FRE_SHIFT: begin
        issue = (ptr < cnt);
        if (issue) begin
          rd_en      = 1'b1;
          ptr_next   = ptr + CW'(1);
          pend_next  = 1'b1;
          rd_at_next = ptr[AW-1:0];
        end
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = rd_at - AW'(gap);
          wt      = rt;
        end
        if (!issue && !pend) begin
          cnt_next   = cnt - CW'(gap);
          resp_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

// ===== hdl/best_fit_pool_allocator.sv =====
// top level of the best-fit pool allocator: tile table ram, sequencer, output register
//
// Usage:
//   Request channel (req_valid/req_ready/req) carries one beat per command:
//   opcode 0 allocates req_size bytes, opcode 1 frees the payload at address.
//   Response channel (rsp_valid/rsp_ready/rsp) returns one beat per command
//   with status and payload_offset, in command order.
//   The tile table sits in one ram with a registered read; every command
//   other than a zero size allocate or an out-of-range free walks it
//   through the single read port, one tile per cycle; those two are
//   answered from idle without a walk. An allocate that splits a tile
//   also shifts the entries above it up by one.
//   One command is in work at a time; the next is taken once the sequencer
//   is idle and holds no response still waiting to be handed on.
//   Reset: synchronous on rst; after reset the init state writes the single
//   pool-wide free tile, then the request channel opens.
//   Stall: a finished response waits in the output register while the next
//   command is already being taken; a second response holds the sequencer
//   until rsp_ready frees the register.
module best_fit_pool_allocator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  bfpa_pkg::in_beat_t   req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output bfpa_pkg::out_beat_t  rsp
);

  logic                          res_valid;
  logic                          res_ready;
  bfpa_pkg::out_beat_t           res;
  logic                          rd_en;
  logic [bfpa_pkg::ADDR_W-1:0]   rd_addr;
  logic [bfpa_pkg::TILE_W-1:0]   rd_data;
  logic                          wr_en;
  logic [bfpa_pkg::ADDR_W-1:0]   wr_addr;
  logic [bfpa_pkg::TILE_W-1:0]   wr_data;

  // tile table
  bfpa_ram #(
    .WIDTH (bfpa_pkg::TILE_W),
    .DEPTH (bfpa_pkg::MAX_TILES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bfpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (req_valid),
    .cmd_ready (req_ready),
    .cmd       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // output register between sequencer and response channel
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule
